// ----- hdl/gzr_pkg.sv -----
package gzr_pkg;

    localparam int SCR_W     = 13;
    localparam int POS_W     = 12;
    localparam int DIV_W     = 5;
    localparam int REM_W     = 4;
    localparam int ACC_W     = 17;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 4;

    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(SCR_W - 1);
    localparam logic [CNT_W-1:0] SEARCH_LAST = CNT_W'(15);

    localparam logic [SCR_W-1:0] MAX_SCREEN    = SCR_W'(4096);
    localparam logic [DIV_W-1:0] MAX_DIVISIONS = DIV_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(3);

    localparam logic [DIV_W-1:0] RST_GRID_ROWS     = DIV_W'(3);
    localparam logic [DIV_W-1:0] RST_GRID_COLS     = DIV_W'(3);
    localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = SCR_W'(1920);
    localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = SCR_W'(1080);

    typedef struct packed {
        logic             load;
        logic             div_step;
        logic             search_step;
        logic [CNT_W-1:0] step;
        logic             commit;
    } cmd_t;

    function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
        logic [DIV_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIV_W'(1);
        else if (v > MAX_DIVISIONS)
            r = MAX_DIVISIONS;
        return r;
    endfunction

    function automatic logic [SCR_W-1:0] clamp_scr(input logic [SCR_W-1:0] v);
        logic [SCR_W-1:0] r;
        r = v;
        if (v == '0)
            r = SCR_W'(1);
        else if (v > MAX_SCREEN)
            r = MAX_SCREEN;
        return r;
    endfunction

endpackage

// ----- hdl/gzr_div.sv -----
module gzr_div (
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [gzr_pkg::SCR_W-1:0]   dividend,
    input  logic [gzr_pkg::DIV_W-1:0]   divisor,
    output logic [gzr_pkg::SCR_W-1:0]   quotient,
    output logic [gzr_pkg::REM_W-1:0]   remainder
);

    logic [gzr_pkg::SCR_W-1:0] quo_reg;
    logic [gzr_pkg::REM_W-1:0] rem_reg;
    logic [gzr_pkg::DIV_W-1:0] dsr_reg;
    logic [gzr_pkg::DIV_W-1:0] trial;
    logic                      fits;

    // restoring division, one quotient bit per step, msb first
    assign trial = {rem_reg, quo_reg[gzr_pkg::SCR_W-1]};
    assign fits  = (trial >= dsr_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (step)
        begin
            quo_reg <= {quo_reg[gzr_pkg::SCR_W-2:0], fits};
            rem_reg <= fits ? gzr_pkg::REM_W'(trial - dsr_reg)
                            : gzr_pkg::REM_W'(trial);
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/gzr_ctrl.sv -----
module gzr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output gzr_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    state_t                    state_reg;
    logic [gzr_pkg::CNT_W-1:0] cnt_reg;
    logic                      out_valid_reg;
    logic                      accept;
    logic                      commit_ok;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    // previous result must have left the output register first
    assign commit_ok = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == gzr_pkg::DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SEARCH;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_SEARCH:
                begin
                    if (cnt_reg == gzr_pkg::SEARCH_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_COMMIT;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_COMMIT:
                begin
                    if (commit_ok)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.load        = accept;
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.search_step = (state_reg == ST_SEARCH);
        cmd.step        = cnt_reg;
        cmd.commit      = commit_ok;
    end

endmodule

// ----- hdl/gzr_datapath.sv -----
module gzr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gzr_pkg::cmd_t                   cmd,
    input  logic                            cfg_we,
    input  logic [gzr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gzr_pkg::SCR_W-1:0]       cfg_data,
    input  logic                            func,
    input  logic [gzr_pkg::SCR_W-1:0]       click_x,
    input  logic [gzr_pkg::SCR_W-1:0]       click_y,
    output logic                            hit,
    output logic [gzr_pkg::POS_W-1:0]       zoom_x,
    output logic [gzr_pkg::POS_W-1:0]       zoom_y,
    output logic [gzr_pkg::SCR_W-1:0]       zoom_width,
    output logic [gzr_pkg::SCR_W-1:0]       zoom_height
);

    // configuration
    logic [gzr_pkg::DIV_W-1:0] rows_reg;
    logic [gzr_pkg::DIV_W-1:0] cols_reg;
    logic [gzr_pkg::SCR_W-1:0] sw_reg;
    logic [gzr_pkg::SCR_W-1:0] sh_reg;

    // zoom rectangle
    logic [gzr_pkg::POS_W-1:0] left_reg,   left_next;
    logic [gzr_pkg::POS_W-1:0] top_reg,    top_next;
    logic [gzr_pkg::SCR_W-1:0] width_reg,  width_next;
    logic [gzr_pkg::SCR_W-1:0] height_reg, height_next;
    logic                      hit_next;

    // item and search
    logic                      func_reg;
    logic [gzr_pkg::SCR_W-1:0] cx_reg;
    logic [gzr_pkg::SCR_W-1:0] cy_reg;
    logic [gzr_pkg::ACC_W-1:0] ax_reg;
    logic [gzr_pkg::ACC_W-1:0] ay_reg;
    logic [gzr_pkg::SCR_W-1:0] ox_reg;
    logic [gzr_pkg::SCR_W-1:0] oy_reg;
    logic                      fx_reg;
    logic                      fy_reg;

    // result register
    logic                      hit_reg;
    logic [gzr_pkg::POS_W-1:0] zx_reg;
    logic [gzr_pkg::POS_W-1:0] zy_reg;
    logic [gzr_pkg::SCR_W-1:0] zw_reg;
    logic [gzr_pkg::SCR_W-1:0] zh_reg;

    logic [gzr_pkg::DIV_W-1:0] rows_eff;
    logic [gzr_pkg::DIV_W-1:0] cols_eff;
    logic [gzr_pkg::SCR_W-1:0] sw_eff;
    logic [gzr_pkg::SCR_W-1:0] sh_eff;

    logic [gzr_pkg::SCR_W-1:0] cw, ch, qx, qy;
    logic [gzr_pkg::REM_W-1:0] cw_rem, ch_rem, rx, ry;

    logic                      x_in, y_in, x_act, y_act;
    logic [gzr_pkg::ACC_W-1:0] ax_hi, ay_hi;
    logic [gzr_pkg::SCR_W-1:0] nw, nh;

    assign rows_eff = gzr_pkg::clamp_div(rows_reg);
    assign cols_eff = gzr_pkg::clamp_div(cols_reg);
    assign sw_eff   = gzr_pkg::clamp_scr(sw_reg);
    assign sh_eff   = gzr_pkg::clamp_scr(sh_reg);

    // cell size and rectangle split, both axes at once
    gzr_div u_div_cw (
        .clk       (clk),
        .start     (cmd.load),
        .step      (cmd.div_step),
        .dividend  (sw_eff),
        .divisor   (cols_eff),
        .quotient  (cw),
        .remainder (cw_rem)
    );

    gzr_div u_div_ch (
        .clk       (clk),
        .start     (cmd.load),
        .step      (cmd.div_step),
        .dividend  (sh_eff),
        .divisor   (rows_eff),
        .quotient  (ch),
        .remainder (ch_rem)
    );

    gzr_div u_div_qx (
        .clk       (clk),
        .start     (cmd.load),
        .step      (cmd.div_step),
        .dividend  (width_reg),
        .divisor   (cols_eff),
        .quotient  (qx),
        .remainder (rx)
    );

    gzr_div u_div_qy (
        .clk       (clk),
        .start     (cmd.load),
        .step      (cmd.div_step),
        .dividend  (height_reg),
        .divisor   (rows_eff),
        .quotient  (qy),
        .remainder (ry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gzr_pkg::RST_GRID_ROWS;
            cols_reg <= gzr_pkg::RST_GRID_COLS;
            sw_reg   <= gzr_pkg::RST_SCREEN_WIDTH;
            sh_reg   <= gzr_pkg::RST_SCREEN_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gzr_pkg::REG_GRID_ROWS:     rows_reg <= cfg_data[gzr_pkg::DIV_W-1:0];
                gzr_pkg::REG_GRID_COLS:     cols_reg <= cfg_data[gzr_pkg::DIV_W-1:0];
                gzr_pkg::REG_SCREEN_WIDTH:  sw_reg   <= cfg_data;
                gzr_pkg::REG_SCREEN_HEIGHT: sh_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // column j holds x when j*cw <= x <= (j+1)*cw, first j wins
    assign ax_hi = ax_reg + gzr_pkg::ACC_W'(cw);
    assign ay_hi = ay_reg + gzr_pkg::ACC_W'(ch);
    assign x_in  = (gzr_pkg::ACC_W'(cx_reg) >= ax_reg) && (gzr_pkg::ACC_W'(cx_reg) <= ax_hi);
    assign y_in  = (gzr_pkg::ACC_W'(cy_reg) >= ay_reg) && (gzr_pkg::ACC_W'(cy_reg) <= ay_hi);
    assign x_act = (gzr_pkg::DIV_W'(cmd.step) < cols_eff) && !fx_reg;
    assign y_act = (gzr_pkg::DIV_W'(cmd.step) < rows_eff) && !fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= 1'b0;
            fy_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            fx_reg <= 1'b0;
            fy_reg <= 1'b0;
        end
        else if (cmd.search_step)
        begin
            if (x_act && x_in)
                fx_reg <= 1'b1;
            if (y_act && y_in)
                fy_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            cx_reg   <= click_x;
            cy_reg   <= click_y;
            ax_reg   <= '0;
            ay_reg   <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end
        else if (cmd.search_step)
        begin
            // offset runs as j * (width / cols) until the column is found
            if (x_act && !x_in)
            begin
                ax_reg <= ax_hi;
                ox_reg <= ox_reg + qx;
            end
            if (y_act && !y_in)
            begin
                ay_reg <= ay_hi;
                oy_reg <= oy_reg + qy;
            end
        end
    end

    assign nw = qx + gzr_pkg::SCR_W'(rx);
    assign nh = qy + gzr_pkg::SCR_W'(ry);

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        width_next  = width_reg;
        height_next = height_reg;
        hit_next    = 1'b0;
        priority if (func_reg)
        begin
            left_next   = '0;
            top_next    = '0;
            width_next  = sw_eff;
            height_next = sh_eff;
        end
        else if (fx_reg && fy_reg)
        begin
            left_next   = left_reg + ox_reg[gzr_pkg::POS_W-1:0];
            top_next    = top_reg + oy_reg[gzr_pkg::POS_W-1:0];
            width_next  = (nw == '0) ? gzr_pkg::SCR_W'(1) : nw;
            height_next = (nh == '0) ? gzr_pkg::SCR_W'(1) : nh;
            hit_next    = 1'b1;
        end
        else
            hit_next    = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= gzr_pkg::RST_SCREEN_WIDTH;
            height_reg <= gzr_pkg::RST_SCREEN_HEIGHT;
        end
        else if (cmd.commit)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= hit_next;
            zx_reg  <= left_next;
            zy_reg  <= top_next;
            zw_reg  <= width_next;
            zh_reg  <= height_next;
        end
    end

    assign hit         = hit_reg;
    assign zoom_x      = zx_reg;
    assign zoom_y      = zy_reg;
    assign zoom_width  = zw_reg;
    assign zoom_height = zh_reg;

endmodule

// ----- hdl/grid_zoom_rect_refiner_core.sv -----
// from input accept to out_valid an item runs a 13-step shift-subtract
// divider pass, a 16-step row/column search and a commit state that waits for the output register
// one item in flight at a time; a new item is accepted only when idle
// reset: asynchronous, active low; config registers return to 3x3 grid, 1920x1080,
// and the zoom rectangle to the full screen
module grid_zoom_rect_refiner_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gzr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gzr_pkg::SCR_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [gzr_pkg::SCR_W-1:0]       click_x,
    input  logic [gzr_pkg::SCR_W-1:0]       click_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [gzr_pkg::POS_W-1:0]       zoom_x,
    output logic [gzr_pkg::POS_W-1:0]       zoom_y,
    output logic [gzr_pkg::SCR_W-1:0]       zoom_width,
    output logic [gzr_pkg::SCR_W-1:0]       zoom_height
);

    gzr_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    gzr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    gzr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .click_x     (click_x),
        .click_y     (click_y),
        .hit         (hit),
        .zoom_x      (zoom_x),
        .zoom_y      (zoom_y),
        .zoom_width  (zoom_width),
        .zoom_height (zoom_height)
    );

endmodule
